### src/cubic_bezier_motion_path_macros.svh
// Assertion helpers shared by the motion path RTL.
// Each one samples on clk and is off while rst_n is low.
`ifndef CUBIC_BEZIER_MOTION_PATH_MACROS_SVH
`define CUBIC_BEZIER_MOTION_PATH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cbmp_pkg.sv
package cbmp_pkg;

  // Fixed-point setup
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int HALF_W     = 16;              // one packed coordinate
  localparam int DUR_W      = 24;
  localparam int TICK_W     = 16;
  localparam int ELAP_W     = 32;

  // Datapath widths
  localparam int UW    = FRAC_BITS + 1;        // t, u, uu, tt: 0 .. 2^F
  localparam int WW    = FRAC_BITS + 2;        // weights up to 3 * 2^F
  localparam int PT_W  = HALF_W + 1;           // curve point, start removed
  localparam int MA_W  = WW + 1;               // signed multiplier operand a
  localparam int MB_W  = PT_W + 1;             // signed multiplier operand b
  localparam int P_W   = MA_W + MB_W;
  localparam int ACC_W = P_W + 2;

  localparam logic [UW-1:0] ONE = UW'(1) << FRAC_BITS;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_MODE = 3'd5;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Curve point relative to start: plain half, or half minus start in absolute mode
  function automatic logic signed [PT_W-1:0] pt_rel(logic [HALF_W-1:0] h,
                                                    logic [HALF_W-1:0] s,
                                                    logic abs_m);
    logic signed [PT_W-1:0] hv;
    logic signed [PT_W-1:0] sv;
    hv = PT_W'($signed(h));
    sv = PT_W'($signed(s));
    return abs_m ? (hv - sv) : hv;
  endfunction

endpackage

### src/cubic_bezier_motion_path.sv
// One item at a time: a new item is accepted only while idle. Each item runs the
//   16-step bit-serial divider, skipped once elapsed time reaches the duration,
//   and then eleven passes through the one shared 19x18 multiplier.
// Reset (rst_n low, synchronous): elapsed time 0, first tick pending, registers
//   at their defaults (duration 1, points 0, relative mode), no result pending.
`include "cubic_bezier_motion_path_macros.svh"

module cubic_bezier_motion_path (
  input  logic                              clk,
  input  logic                              rst_n,
  // input item
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [15:0] tick_time
  input  logic [0:0]                        in_tuser,   // [0] cmd
  // result item
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [55:0]                       out_tdata,  // [15:0] pos_x, [31:16] pos_y,
                                                        // [48:32] progress, [49] done_res
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);
  import cbmp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  // Multiplier schedule: step n issues one product, step n+1 writes it back
  localparam logic [3:0] SP_UU  = 4'd0;   // u*u
  localparam logic [3:0] SP_TT  = 4'd1;   // t*t
  localparam logic [3:0] SP_W1  = 4'd2;   // uu*t
  localparam logic [3:0] SP_W2  = 4'd3;   // tt*u
  localparam logic [3:0] SP_W3  = 4'd4;   // tt*t
  localparam logic [3:0] SP_BX  = 4'd5;
  localparam logic [3:0] SP_CX  = 4'd6;
  localparam logic [3:0] SP_DX  = 4'd7;
  localparam logic [3:0] SP_BY  = 4'd8;
  localparam logic [3:0] SP_CY  = 4'd9;
  localparam logic [3:0] SP_DY  = 4'd10;
  localparam logic [3:0] SP_END = 4'd11;  // last write-back only

  localparam logic signed [ACC_W-1:0] CMAX = ACC_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] CMIN = -CMAX - ACC_W'(1);

  // Registers
  logic [DUR_W-1:0]        dur_r;
  logic [31:0]             start_r;
  logic [31:0]             c1_r;
  logic [31:0]             c2_r;
  logic [31:0]             end_r;
  logic                    abs_r;

  state_t                  state_r;
  logic [ELAP_W-1:0]       elapsed_r;
  logic                    first_r;
  logic                    done_r;
  logic [UW-1:0]           t_r;
  logic [3:0]              step_r;
  logic [UW-1:0]           uu_r;
  logic [UW-1:0]           tt_r;
  logic [WW-1:0]           w1_r;
  logic [WW-1:0]           w2_r;
  logic [WW-1:0]           w3_r;
  logic signed [P_W-1:0]   prod_r;
  logic signed [ACC_W-1:0] accx_r;
  logic signed [ACC_W-1:0] accy_r;

  logic                    out_valid_r;
  logic [HALF_W-1:0]       out_x_r;
  logic [HALF_W-1:0]       out_y_r;
  logic [UW-1:0]           out_prog_r;
  logic                    out_done_r;

  // Combinational
  logic                    in_acc;
  logic                    fin_go;
  logic [DUR_W-1:0]        dur_eff;
  logic [ELAP_W:0]         el_sum;
  logic                    reach;
  logic [UW-1:0]           u_val;
  logic signed [PT_W-1:0]  bx, by, cx, cy, dx, dy;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic [2*UW-1:0]         rsum;
  logic [UW-1:0]           rnd;
  logic [WW-1:0]           rnd3;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] posx;
  logic signed [ACC_W-1:0] posy;

  logic                    div_start;
  logic [FRAC_BITS-1:0]    div_q;
  div_stat_t               div_stat;

  function automatic logic signed [ACC_W-1:0] place(logic signed [ACC_W-1:0] acc,
                                                    logic [HALF_W-1:0] s);
    logic signed [ACC_W-1:0] v;
    v = ((acc + ACC_W'(HALF)) >>> FRAC_BITS) + ACC_W'($signed(s));
    if (v > CMAX)      return CMAX;
    else if (v < CMIN) return CMIN;
    else               return v;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  assign dur_eff   = (dur_r == '0) ? DUR_W'(1) : dur_r;
  assign el_sum    = {1'b0, elapsed_r} + (ELAP_W + 1)'(in_tdata);
  assign reach     = (elapsed_r >= ELAP_W'(dur_eff));
  assign u_val     = ONE - t_r;
  assign div_start = (state_r == ST_PREP) && !reach;

  // Curve points relative to start
  assign bx = pt_rel(c1_r[31:16],  start_r[31:16], abs_r);
  assign by = pt_rel(c1_r[15:0],   start_r[15:0],  abs_r);
  assign cx = pt_rel(c2_r[31:16],  start_r[31:16], abs_r);
  assign cy = pt_rel(c2_r[15:0],   start_r[15:0],  abs_r);
  assign dx = pt_rel(end_r[31:16], start_r[31:16], abs_r);
  assign dy = pt_rel(end_r[15:0],  start_r[15:0],  abs_r);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      SP_UU: begin mul_a = MA_W'(u_val); mul_b = MB_W'(u_val); end
      SP_TT: begin mul_a = MA_W'(t_r);   mul_b = MB_W'(t_r);   end
      SP_W1: begin mul_a = MA_W'(uu_r);  mul_b = MB_W'(t_r);   end
      SP_W2: begin mul_a = MA_W'(tt_r);  mul_b = MB_W'(u_val); end
      SP_W3: begin mul_a = MA_W'(tt_r);  mul_b = MB_W'(t_r);   end
      SP_BX: begin mul_a = MA_W'(w1_r);  mul_b = MB_W'(bx);    end
      SP_CX: begin mul_a = MA_W'(w2_r);  mul_b = MB_W'(cx);    end
      SP_DX: begin mul_a = MA_W'(w3_r);  mul_b = MB_W'(dx);    end
      SP_BY: begin mul_a = MA_W'(w1_r);  mul_b = MB_W'(by);    end
      SP_CY: begin mul_a = MA_W'(w2_r);  mul_b = MB_W'(cy);    end
      SP_DY: begin mul_a = MA_W'(w3_r);  mul_b = MB_W'(dy);    end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Round-half-up of an unsigned product, and three times that
  assign rsum     = prod_r[2*UW-1:0] + (2*UW)'(HALF);
  assign rnd      = rsum[FRAC_BITS+UW-1:FRAC_BITS];
  assign rnd3     = {rnd, 1'b0} + WW'(rnd);
  assign prod_ext = {{(ACC_W-P_W){prod_r[P_W-1]}}, prod_r};

  assign posx = place(accx_r, start_r[31:16]);
  assign posy = place(accy_r, start_r[15:0]);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r   <= DUR_W'(1);
      start_r <= '0;
      c1_r    <= '0;
      c2_r    <= '0;
      end_r   <= '0;
      abs_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DURATION: dur_r   <= cfg_data[DUR_W-1:0];
        REG_START:    start_r <= cfg_data;
        REG_CTRL1:    c1_r    <= cfg_data;
        REG_CTRL2:    c2_r    <= cfg_data;
        REG_END:      end_r   <= cfg_data;
        REG_ABS_MODE: abs_r   <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Sequencer and timing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      first_r     <= 1'b1;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !fin_go) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser[0]) begin
              elapsed_r <= '0;
              first_r   <= 1'b1;
            end else if (first_r) begin
              elapsed_r <= '0;
              first_r   <= 1'b0;
            end else begin
              elapsed_r <= el_sum[ELAP_W] ? '1 : el_sum[ELAP_W-1:0];
            end
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          step_r  <= SP_UU;
          state_r <= reach ? ST_MUL : ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) state_r <= ST_MUL;
        end
        ST_MUL: begin
          step_r <= step_r + 4'd1;
          if (step_r == SP_END) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath: progress, product pipeline, write-back
  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      done_r <= reach;
      t_r    <= ONE;
    end
    if ((state_r == ST_DIV) && div_stat.done) t_r <= UW'(div_q);
    if (state_r == ST_MUL) begin
      prod_r <= mul_a * mul_b;
      case (step_r)
        SP_TT:  uu_r   <= rnd;
        SP_W1:  tt_r   <= rnd;
        SP_W2:  w1_r   <= rnd3;
        SP_W3:  w2_r   <= rnd3;
        SP_BX:  w3_r   <= WW'(rnd);
        SP_CX:  accx_r <= prod_ext;
        SP_DX:  accx_r <= accx_r + prod_ext;
        SP_BY:  accx_r <= accx_r + prod_ext;
        SP_CY:  accy_r <= prod_ext;
        SP_DY:  accy_r <= accy_r + prod_ext;
        SP_END: accy_r <= accy_r + prod_ext;
        default: ;
      endcase
    end
    if (fin_go) begin
      out_x_r    <= posx[HALF_W-1:0];
      out_y_r    <= posy[HALF_W-1:0];
      out_prog_r <= t_r;
      out_done_r <= done_r;
    end
  end

  cbmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (elapsed_r[DUR_W-1:0]),
    .den   (dur_eff),
    .quot  (div_q),
    .stat  (div_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_done_r, out_prog_r, out_y_r, out_x_r};

  // Checks
  `CBMP_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready, "accepted a second item while busy")
  `CBMP_ASSERT_NOW(a_div_in_div_state, div_stat.busy, state_r == ST_DIV, "divider runs outside divide phase")
  `CBMP_ASSERT_NOW(a_step_bound, state_r == ST_MUL, step_r <= SP_END, "multiply step out of range")
  `CBMP_ASSERT_NOW(a_done_full, out_valid_r && out_done_r, out_prog_r == ONE, "done without full progress")

endmodule

### src/cbmp_div.sv
module cbmp_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [cbmp_pkg::DUR_W-1:0]      num,    // must be below den
  input  logic [cbmp_pkg::DUR_W-1:0]      den,
  output logic [cbmp_pkg::FRAC_BITS-1:0]  quot,   // floor(num * 2^F / den)
  output cbmp_pkg::div_stat_t             stat
);
  import cbmp_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [DUR_W-1:0]     rem_r;
  logic [FRAC_BITS-1:0] quot_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DUR_W:0]       rem_sh;
  logic                 ge;
  logic [DUR_W:0]       rem_nxt;

  // One restoring step: shift in a zero, subtract when it fits
  always_comb begin
    rem_sh  = {rem_r, 1'b0};
    ge      = (rem_sh >= {1'b0, den});
    rem_nxt = ge ? (rem_sh - {1'b0, den}) : rem_sh;
  end

  // Control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
    end else if (busy_r) begin
      rem_r  <= rem_nxt[DUR_W-1:0];
      quot_r <= {quot_r[FRAC_BITS-2:0], ge};
    end
  end

  assign quot      = quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
